// ===== rtl/sdtw_pkg.sv =====
// Shared constants, types and codes of the subsequence DTW cost block.
`default_nettype none
package sdtw_pkg;

  localparam int QUERY_DEPTH = 512;
  localparam int QA_W        = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int LEN_W       = $clog2(QUERY_DEPTH + 1);
  localparam int SAMPLE_W    = 16;
  localparam int COST_W      = 32;
  localparam int POS_W       = 20;
  localparam int QIDX_W      = 9;
  localparam int QLEN_CFG_W  = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  localparam logic [COST_W-1:0] COST_INF = '1;
  localparam logic [POS_W-1:0]  POS_MAX  = '1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REF  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LENGTH = 1'b0,
    CFG_EXCLUDE_LAST = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                       start;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           len;
  } eng_ctl_t;

  typedef struct packed {
    logic                en;
    logic [QA_W-1:0]     addr;
    logic [SAMPLE_W-1:0] data;
  } qwr_t;

  typedef struct packed {
    logic                done;
    logic [COST_W-1:0]   end_cost;
    logic [SAMPLE_W-1:0] last_dist;
  } eng_sts_t;

endpackage
`default_nettype wire

// ===== rtl/sdtw_in_if.sv =====
// Input channel of the subsequence DTW cost block.
`default_nettype none
interface sdtw_in_if;
  import sdtw_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [QIDX_W-1:0]          query_index;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       first_of_reference;

  modport source (output valid, func, query_index, sample, first_of_reference, input ready);
  modport sink (input valid, func, query_index, sample, first_of_reference, output ready);
endinterface
`default_nettype wire

// ===== rtl/sdtw_out_if.sv =====
// Result channel of the subsequence DTW cost block.
`default_nettype none
interface sdtw_out_if;
  import sdtw_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] end_cost;
  logic [COST_W-1:0] best_cost;
  logic [POS_W-1:0]  best_end;

  modport source (output valid, end_cost, best_cost, best_end, input ready);
  modport sink (input valid, end_cost, best_cost, best_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/sdtw_col_engine.sv =====
// Query store, cost column memory and the pipelined column update datapath.
`default_nettype none
module sdtw_col_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  sdtw_pkg::eng_ctl_t ctl_i,
  input  sdtw_pkg::qwr_t     qwr_i,
  output sdtw_pkg::eng_sts_t sts_o
);
  import sdtw_pkg::*;

  logic [SAMPLE_W-1:0] q_mem   [QUERY_DEPTH];
  logic [COST_W-1:0]   col_mem [QUERY_DEPTH];

  logic                       busy_r;
  logic [LEN_W-1:0]           rd_idx_r;
  logic [LEN_W-1:0]           len_r;
  logic [LEN_W-1:0]           hi_r;
  logic signed [SAMPLE_W-1:0] sample_r;

  logic                b_vld_r;
  logic [QA_W-1:0]     b_idx_r;
  logic                b_first_r;
  logic                b_last_r;
  logic [SAMPLE_W-1:0] q_rd_r;
  logic [COST_W-1:0]   col_rd_r;
  logic [COST_W-1:0]   diag_r;

  logic                c_vld_r;
  logic [QA_W-1:0]     c_idx_r;
  logic                c_first_r;
  logic                c_last_r;
  logic [SAMPLE_W-1:0] c_d_r;
  logic [COST_W-1:0]   c_m_r;
  logic [COST_W-1:0]   prev_r;

  logic                done_r;
  logic [COST_W-1:0]   end_r;
  logic [SAMPLE_W-1:0] last_d_r;

  logic                issue;
  logic [SAMPLE_W:0]   diff_b;
  logic [SAMPLE_W:0]   abs_b;
  logic [SAMPLE_W-1:0] d_b;
  logic [COST_W-1:0]   left_b;
  logic [COST_W-1:0]   m_b;
  logic [COST_W-1:0]   m_c;
  logic [COST_W:0]     sum_c;
  logic [COST_W-1:0]   new_cost;

  assign issue = busy_r && (rd_idx_r < len_r);

  always_ff @(posedge clk) begin
    if (qwr_i.en) begin
      q_mem[qwr_i.addr] <= qwr_i.data;
    end
    if (issue) begin
      q_rd_r   <= q_mem[rd_idx_r[QA_W-1:0]];
      col_rd_r <= col_mem[rd_idx_r[QA_W-1:0]];
    end
    if (c_vld_r) begin
      col_mem[c_idx_r] <= new_cost;
    end
  end

  // Entries at or above the fill count were not written in this run and read as infinity.
  always_comb begin
    diff_b = {q_rd_r[SAMPLE_W-1], q_rd_r} - {sample_r[SAMPLE_W-1], sample_r};
    abs_b  = diff_b[SAMPLE_W] ? (~diff_b + 1'b1) : diff_b;
    d_b    = abs_b[SAMPLE_W-1:0];
    left_b = (LEN_W'(b_idx_r) < hi_r) ? col_rd_r : COST_INF;
    m_b    = (left_b < diag_r) ? left_b : diag_r;
  end

  always_comb begin
    m_c   = (prev_r < c_m_r) ? prev_r : c_m_r;
    sum_c = {1'b0, m_c} + (COST_W+1)'(c_d_r);
    if (c_first_r) begin
      new_cost = COST_W'(c_d_r);
    end else if (sum_c >= {1'b0, COST_INF}) begin
      new_cost = COST_INF;
    end else begin
      new_cost = sum_c[COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_idx_r <= '0;
      hi_r     <= '0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      b_vld_r <= issue;
      c_vld_r <= b_vld_r;
      done_r  <= c_vld_r && c_last_r;
      if (ctl_i.start) begin
        busy_r   <= 1'b1;
        rd_idx_r <= '0;
        if (ctl_i.first) begin
          hi_r <= '0;
        end
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (c_vld_r && c_last_r) begin
        busy_r <= 1'b0;
        hi_r   <= (len_r > hi_r) ? len_r : hi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.start) begin
      sample_r <= ctl_i.sample;
      len_r    <= ctl_i.len;
    end
    b_idx_r   <= rd_idx_r[QA_W-1:0];
    b_first_r <= (rd_idx_r == '0);
    b_last_r  <= (rd_idx_r == len_r - LEN_W'(1));
    if (b_vld_r) begin
      diag_r <= left_b;
    end
    c_idx_r   <= b_idx_r;
    c_first_r <= b_first_r;
    c_last_r  <= b_last_r;
    c_d_r     <= d_b;
    c_m_r     <= m_b;
    if (c_vld_r) begin
      prev_r <= new_cost;
      if (c_last_r) begin
        end_r    <= new_cost;
        last_d_r <= c_d_r;
      end
    end
  end

  assign sts_o.done      = done_r;
  assign sts_o.end_cost  = end_r;
  assign sts_o.last_dist = last_d_r;

endmodule
`default_nettype wire

// ===== rtl/subsequence_dtw_cost_top.sv =====
// Subsequence dynamic time warping cost block, top level.
// Use: set query_length and exclude_last through the cfg_ write port while idle.
// Load the query with func 0 transfers, one sample per transfer at query_index;
// each load gives no result. Then stream reference samples
// with func 1; first_of_reference 1 starts a new run and clears the column and
// the running best. Each reference transfer yields one result transfer with
// end_cost, best_cost and best_end.
// The result of a reference sample is registered after its column pass, paced
// by the column memory port that reads one query entry and one column entry
// per cycle. in_ch.ready is low while a sample is in work and returns with the
// registered result, even if that result is still waiting, so a new reference
// sample is taken only once the last one is through.
// The column memory needs no clearing pass: a fill count marks which entries
// hold costs of the current run, and all others read as infinity.
// Reset is synchronous: query_length returns to 1, exclude_last to 0, the run
// state to a fresh run; the query store keeps no defined contents.
// A stalled receiver holds the result register; the block then finishes its
// current sample and waits before taking another.
`default_nettype none
module subsequence_dtw_cost_top (
  input  logic                                clk,
  input  logic                                rst_n,
  sdtw_in_if.sink                             in_ch,
  sdtw_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [sdtw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdtw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sdtw_pkg::*;

  state_t state_r, state_nxt;

  logic [QLEN_CFG_W-1:0] qlen_r;
  logic                  excl_r;
  logic [COST_W-1:0]     best_raw_r;
  logic [COST_W-1:0]     best_adj_r;
  logic [POS_W-1:0]      best_pos_r;
  logic [POS_W-1:0]      ref_pos_r;

  logic              out_vld_r;
  logic [COST_W-1:0] out_end_r;
  logic [COST_W-1:0] out_best_r;
  logic [POS_W-1:0]  out_pos_r;

  logic              in_acc;
  logic              start;
  logic              out_load;
  logic [LEN_W-1:0]  eff_len;
  logic              better;
  logic [COST_W-1:0] adj_new;
  logic [COST_W-1:0] raw_sel;
  logic [COST_W-1:0] adj_sel;
  logic [POS_W-1:0]  pos_sel;

  eng_ctl_t ctl;
  qwr_t     qwr;
  eng_sts_t sts;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign start       = in_acc && (in_ch.func == FUNC_REF);

  always_comb begin
    if (qlen_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(qlen_r) > QUERY_DEPTH) begin
      eff_len = LEN_W'(QUERY_DEPTH);
    end else begin
      eff_len = LEN_W'(qlen_r);
    end
  end

  assign ctl.start  = start;
  assign ctl.first  = in_ch.first_of_reference;
  assign ctl.sample = in_ch.sample;
  assign ctl.len    = eff_len;

  assign qwr.en   = in_acc && (in_ch.func == FUNC_LOAD) && (int'(in_ch.query_index) < QUERY_DEPTH);
  assign qwr.addr = QA_W'(in_ch.query_index);
  assign qwr.data = in_ch.sample;

  sdtw_col_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl),
    .qwr_i (qwr),
    .sts_o (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A strict compare keeps the first minimum on ties.
  always_comb begin
    better  = sts.end_cost < best_raw_r;
    adj_new = (sts.end_cost == COST_INF) ? COST_INF
                                         : sts.end_cost - COST_W'(sts.last_dist);
    raw_sel = better ? sts.end_cost : best_raw_r;
    adj_sel = better ? adj_new : best_adj_r;
    pos_sel = better ? ref_pos_r : best_pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_raw_r <= COST_INF;
      best_adj_r <= COST_INF;
      best_pos_r <= '0;
      ref_pos_r  <= '0;
    end else if (start && in_ch.first_of_reference) begin
      best_raw_r <= COST_INF;
      best_adj_r <= COST_INF;
      best_pos_r <= '0;
      ref_pos_r  <= '0;
    end else if (out_load) begin
      best_raw_r <= raw_sel;
      best_adj_r <= adj_sel;
      best_pos_r <= pos_sel;
      if (ref_pos_r != POS_MAX) begin
        ref_pos_r <= ref_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_end_r  <= sts.end_cost;
      out_best_r <= excl_r ? adj_sel : raw_sel;
      out_pos_r  <= pos_sel;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.end_cost  = out_end_r;
  assign out_ch.best_cost = out_best_r;
  assign out_ch.best_end  = out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= QLEN_CFG_W'(1);
      excl_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_QUERY_LENGTH: qlen_r <= cfg_wdata[QLEN_CFG_W-1:0];
        CFG_EXCLUDE_LAST: excl_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sdtw_checker.sv =====
// Port-level checks of the subsequence DTW cost block, bound to its top level.
`default_nettype none
module sdtw_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_func,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [sdtw_pkg::COST_W-1:0]         end_cost,
  input logic [sdtw_pkg::COST_W-1:0]         best_cost,
  input logic                                cfg_we,
  input logic [sdtw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [sdtw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sdtw_pkg::*;

  logic excl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_r <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_EXCLUDE_LAST)) begin
      excl_r <= cfg_wdata[0];
    end
  end

  // A reference sample keeps the input closed while its column is updated.
  a_busy_after_ref: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_REF) |=> !in_ready)
    else $error("input still open right after a reference sample transfer");

  // A query load never produces a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_LOAD) && !out_valid |=> !out_valid)
    else $error("result appeared after a query load");

  // The running minimum can never exceed the current end cost.
  a_best_le_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !excl_r |-> best_cost <= end_cost)
    else $error("best cost above end cost");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(end_cost) && $stable(best_cost))
    else $error("stalled result changed");

endmodule

bind subsequence_dtw_cost_top sdtw_checker u_sdtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .end_cost  (out_ch.end_cost),
  .best_cost (out_ch.best_cost),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);
`default_nettype wire

// ===== test/subsequence_dtw_cost_checker.sv =====
// Watches the subsequence DTW cost channels, predicts every cost report and compares it.
module subsequence_dtw_cost_checker
  import sdtw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sdtw_in_if                    in_mon,
  sdtw_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    error_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [COST_W-1:0] end_cost;
    logic [COST_W-1:0] best_cost;
    logic [POS_W-1:0]  best_end;
  } cost_report_t;

  cost_report_t               report_q[$];
  logic [SAMPLE_W-1:0]        query_mem [QUERY_DEPTH];
  logic [COST_W-1:0]          column [QUERY_DEPTH];
  logic [COST_W-1:0]          best_raw;
  logic [COST_W-1:0]          best_adj;
  logic [POS_W-1:0]           best_pos;
  logic [POS_W-1:0]           ref_pos;
  logic [QLEN_CFG_W-1:0]      qlen_reg;
  logic                       excl_reg;
  int                         mismatches = 0;

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  function automatic logic [COST_W-1:0] abs_gap(input logic [SAMPLE_W-1:0] a,
                                                input logic [SAMPLE_W-1:0] b);
    int sa;
    int sb;
    sa = $signed(a);
    sb = $signed(b);
    return (sa > sb) ? sa - sb : sb - sa;
  endfunction

  task automatic clear_run();
    for (int k = 0; k < QUERY_DEPTH; k++) column[k] = COST_INF;
    best_raw = COST_INF;
    best_adj = COST_INF;
    best_pos = '0;
    ref_pos  = '0;
  endtask

  // One reference sample sweeps the whole column in use and yields one report.
  task automatic advance_column(input logic [SAMPLE_W-1:0] r, input logic first);
    int                n;
    logic [COST_W-1:0] diag;
    logic [COST_W-1:0] left;
    logic [COST_W-1:0] up;
    logic [COST_W-1:0] m;
    logic [COST_W-1:0] d;
    logic [COST_W-1:0] last_d;
    logic [COST_W-1:0] endc;
    logic [COST_W:0]   sum;
    cost_report_t      rep;
    if (first) clear_run();
    n = qlen_reg;
    if (n == 0) n = 1;
    if (n > QUERY_DEPTH) n = QUERY_DEPTH;
    diag = column[0];
    column[0] = abs_gap(query_mem[0], r);
    last_d = column[0];
    for (int j = 1; j < n; j++) begin
      left = column[j];
      up   = column[j-1];
      d    = abs_gap(query_mem[j], r);
      m    = (up < left) ? up : left;
      m    = (m < diag) ? m : diag;
      sum  = {1'b0, m} + {1'b0, d};
      column[j] = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_W-1:0];
      diag   = left;
      last_d = d;
    end
    endc = column[n-1];
    // A strict compare keeps the earliest position on equal costs.
    if (endc < best_raw) begin
      best_raw = endc;
      best_adj = (endc == COST_INF) ? COST_INF : endc - last_d;
      best_pos = ref_pos;
    end
    if (ref_pos != POS_MAX) ref_pos = ref_pos + 1'b1;
    rep.end_cost  = endc;
    rep.best_cost = excl_reg ? best_adj : best_raw;
    rep.best_end  = best_pos;
    report_q.push_back(rep);
  endtask

  always @(posedge clk) begin
    cost_report_t exp_rep;
    if (!rst_n) begin
      clear_run();
      qlen_reg = 1;
      excl_reg = 1'b0;
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_QUERY_LENGTH: qlen_reg = cfg_wdata[QLEN_CFG_W-1:0];
          CFG_EXCLUDE_LAST: excl_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.func == FUNC_LOAD) begin
          if (in_mon.query_index < QUERY_DEPTH) query_mem[in_mon.query_index] = in_mon.sample;
        end else begin
          advance_column(in_mon.sample, in_mon.first_of_reference);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: end_cost %0d best_cost %0d best_end %0d",
                     out_mon.end_cost, out_mon.best_cost, out_mon.best_end);
        end else begin
          exp_rep = report_q.pop_front();
          if (out_mon.end_cost !== exp_rep.end_cost || out_mon.best_cost !== exp_rep.best_cost ||
              out_mon.best_end !== exp_rep.best_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cost report mismatch: end_cost exp %0d got %0d, best_cost exp %0d got %0d, best_end exp %0d got %0d",
                       exp_rep.end_cost, out_mon.end_cost, exp_rep.best_cost,
                       out_mon.best_cost, exp_rep.best_end, out_mon.best_end);
          end
        end
      end
    end
    error_count <= mismatches;
    outstanding <= report_q.size();
  end

endmodule

// ===== test/subsequence_dtw_cost_top_test.sv =====
// Stimulus and verdict for the subsequence DTW cost block: query loads, reference streams, config phases.
module subsequence_dtw_cost_top_test;
  import sdtw_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_TICKS = 16;
  localparam int TAIL_TICKS   = 600;
  localparam int ITEM_TARGET  = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sdtw_in_if  in_ch();
  sdtw_out_if out_ch();

  logic                   tx_valid = 1'b0;
  logic                   tx_func = FUNC_LOAD;
  logic [QIDX_W-1:0]      tx_index = '0;
  logic [SAMPLE_W-1:0]    tx_sample = '0;
  logic                   tx_first = 1'b0;
  logic                   rx_ready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  assign in_ch.valid              = tx_valid;
  assign in_ch.func               = tx_func;
  assign in_ch.query_index        = tx_index;
  assign in_ch.sample             = tx_sample;
  assign in_ch.first_of_reference = tx_first;
  assign out_ch.ready             = rx_ready;

  int errors;
  int outstanding;

  subsequence_dtw_cost_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  subsequence_dtw_cost_checker cost_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .error_count (errors),
    .outstanding (outstanding)
  );

  // The receiver switches between steady, choppy and mostly stalled spans.
  int ready_mode = 0;
  int ready_span = 0;
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_span <= $urandom_range(5, 60);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= ($urandom_range(0, 1) != 0);
      2: rx_ready <= ($urandom_range(0, 7) == 0);
      default: rx_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("subsequence_dtw_cost_top test failed");
      $finish;
    end
  end

  logic [SAMPLE_W-1:0] query_val [QUERY_DEPTH];
  bit                  loaded [QUERY_DEPTH];
  int                  eff_len = 1;
  int                  burst_left = 0;
  int                  items_sent = 0;
  logic [SAMPLE_W-1:0] last_sample = '0;

  task automatic send_item(input logic f, input logic [QIDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] smp, input logic first);
    int gap;
    tx_valid  <= 1'b1;
    tx_func   <= f;
    tx_index  <= idx;
    tx_sample <= smp;
    tx_first  <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        tx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_query(input int idx, input logic [SAMPLE_W-1:0] val);
    send_item(FUNC_LOAD, idx[QIDX_W-1:0], val, ($urandom_range(0, 1) != 0));
    query_val[idx] = val;
    loaded[idx] = 1'b1;
  endtask

  task automatic send_reference(input logic [SAMPLE_W-1:0] val, input logic first);
    send_item(FUNC_REF, QIDX_W'($urandom_range(0, QUERY_DEPTH - 1)), val, first);
    last_sample = val;
  endtask

  // Every query entry in use must hold a written sample before a reference transfer.
  task automatic fill_query();
    for (int k = 0; k < eff_len; k++)
      if (!loaded[k]) load_query(k, SAMPLE_W'($urandom));
  endtask

  task automatic drain(input int extra);
    tx_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_config(input logic [QLEN_CFG_W-1:0] len_val, input logic excl_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUERY_LENGTH;
    cfg_wdata <= len_val;
    @(posedge clk);
    cfg_index <= CFG_EXCLUDE_LAST;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, excl_val};
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_len = (len_val == 0) ? 1 : ((len_val > QUERY_DEPTH) ? QUERY_DEPTH : len_val);
  endtask

  // Mostly wide random values, but also near copies of the query and repeats for ties.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int k;
    k = $urandom_range(0, eff_len - 1);
    case ($urandom_range(0, 9))
      5, 6, 7: return SAMPLE_W'(query_val[k] + $urandom_range(0, 8) - 4);
      8: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      9: return last_sample;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int r;
    int n;
    logic [QLEN_CFG_W-1:0] len_val;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A length of zero acts as one; the first reference after reset has no start mark.
    set_config(10'd0, 1'b1);
    load_query(0, 16'h8000);
    load_query(QUERY_DEPTH - 1, 16'h7FFF);
    send_reference(16'h7FFF, 1'b0);
    send_reference(16'h7FFF, 1'b0);
    send_reference(16'h8000, 1'b0);
    send_reference(16'h0000, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'h8001, 1'b1);
    drain(SETTLE_TICKS);

    set_config(10'd4, 1'b0);
    load_query(1, 16'h7FFF);
    load_query(2, 16'h0000);
    load_query(3, 16'hFFFF);
    send_reference(16'h8000, 1'b1);
    send_reference(16'h7FFF, 1'b0);
    send_reference(16'h0000, 1'b0);
    send_reference(16'h0000, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    load_query(2, 16'h1234);
    send_reference(16'h1234, 1'b0);
    drain(SETTLE_TICKS);

    // Growing the length mid-run leaves the new entries at infinity.
    set_config(10'd1023, 1'b1);
    fill_query();
    send_reference(16'h0100, 1'b0);
    send_reference(16'hFF00, 1'b0);
    drain(SETTLE_TICKS);
    set_config(10'd512, 1'b0);
    send_reference(16'h0000, 1'b1);
    send_reference(16'h7FFF, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 3) len_val = 10'd0;
      else if (r < 5) len_val = 10'd512;
      else if (r < 7) len_val = QLEN_CFG_W'($urandom_range(513, 1023));
      else if (r < 22) len_val = QLEN_CFG_W'($urandom_range(17, 64));
      else len_val = QLEN_CFG_W'($urandom_range(1, 16));
      drain(SETTLE_TICKS);
      set_config(len_val, ($urandom_range(0, 1) != 0));
      fill_query();
      n = (eff_len > 64) ? $urandom_range(2, 4) : $urandom_range(5, 40);
      send_reference(pick_sample(), $urandom_range(0, 3) != 0);
      for (int i = 1; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) load_query($urandom_range(0, QUERY_DEPTH - 1), SAMPLE_W'($urandom));
        else send_reference(pick_sample(), r < 11);
      end
    end

    drain(TAIL_TICKS);
    if (errors == 0) begin
      $display("subsequence_dtw_cost_top test passed");
    end else begin
      $display("subsequence_dtw_cost_top test failed");
    end
    $finish;
  end

endmodule
